[src/csvfs_pkg.sv]
// shared types, constants and character match helpers for the csv field splitter
package csvfs_pkg;

	localparam int DELIM_SLOTS = 4;
	localparam int QUOTE_SLOTS = 2;
	localparam int COUNT_BITS  = 8;

	localparam int DELIM_BITS  = 32;
	localparam int QUOTE_BITS  = 16;
	localparam int HEADER_BITS = 8;
	localparam int CHAR_BITS   = 8;
	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_IDX_BITS  = 2;

	// slots that actually fit in the register
	localparam int DELIM_USED = (DELIM_SLOTS < DELIM_BITS / CHAR_BITS) ?
		DELIM_SLOTS : DELIM_BITS / CHAR_BITS;
	localparam int QUOTE_USED = (QUOTE_SLOTS < QUOTE_BITS / CHAR_BITS) ?
		QUOTE_SLOTS : QUOTE_BITS / CHAR_BITS;

	localparam logic [CHAR_BITS-1:0] BACKSLASH_CODE = 8'd92;
	localparam logic [CHAR_BITS-1:0] NUL_CODE       = 8'd0;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX     = '1;
	localparam logic [HEADER_BITS-1:0] SKIP_MAX     = '1;

	localparam logic [DELIM_BITS-1:0]  DELIM_RESET  = 32'd44;
	localparam logic [QUOTE_BITS-1:0]  QUOTE_RESET  = 16'd34;
	localparam logic [HEADER_BITS-1:0] HEADER_RESET = 8'd0;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_DELIM  = 2'd0,
		REG_QUOTE  = 2'd1,
		REG_HEADER = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [CHAR_BITS-1:0] char_code;
		logic                 is_line_end;
	} in_t;

	typedef struct packed {
		logic [CHAR_BITS-1:0] out_char;
		logic                 char_valid;
		logic                 field_end;
		logic                 row_end;
		logic [7:0]           row_field_count;
	} out_t;

	typedef struct packed {
		logic [DELIM_BITS-1:0]  delimiter_chars;
		logic [QUOTE_BITS-1:0]  quote_chars;
		logic [HEADER_BITS-1:0] header_lines;
	} cfg_t;

	function automatic logic delim_match(input logic [DELIM_BITS-1:0] slots,
		input logic [CHAR_BITS-1:0] c);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < DELIM_USED; i++) begin
			if (slots[CHAR_BITS*i +: CHAR_BITS] != NUL_CODE &&
			    slots[CHAR_BITS*i +: CHAR_BITS] == c)
				hit = 1'b1;
		end
		return hit;
	endfunction

	function automatic logic quote_match(input logic [QUOTE_BITS-1:0] slots,
		input logic [CHAR_BITS-1:0] c);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < QUOTE_USED; i++) begin
			if (slots[CHAR_BITS*i +: CHAR_BITS] != NUL_CODE &&
			    slots[CHAR_BITS*i +: CHAR_BITS] == c)
				hit = 1'b1;
		end
		return hit;
	endfunction

endpackage

[src/csvfs_cfg_regs.sv]
// configuration registers of the csv field splitter
module csvfs_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [csvfs_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [csvfs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output csvfs_pkg::cfg_t                      cfg
);
	import csvfs_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delimiter_chars <= DELIM_RESET;
			cfg_q.quote_chars     <= QUOTE_RESET;
			cfg_q.header_lines    <= HEADER_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_DELIM:  cfg_q.delimiter_chars <= cfg_data[DELIM_BITS-1:0];
				REG_QUOTE:  cfg_q.quote_chars     <= cfg_data[QUOTE_BITS-1:0];
				REG_HEADER: cfg_q.header_lines    <= cfg_data[HEADER_BITS-1:0];
				default:    ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[src/csvfs_step.sv]
// tokenizer state and the per-word next-state and result logic
module csvfs_step (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  csvfs_pkg::in_t  item,
	input  csvfs_pkg::cfg_t cfg,
	output csvfs_pkg::out_t res
);
	import csvfs_pkg::*;

	logic                   escape_pending_q;
	logic [CHAR_BITS-1:0]   open_quote_q;
	logic                   field_nonempty_q;
	logic [COUNT_BITS-1:0]  fields_in_row_q;
	logic [HEADER_BITS-1:0] lines_skipped_q;

	logic                   escape_pending_d;
	logic [CHAR_BITS-1:0]   open_quote_d;
	logic                   field_nonempty_d;
	logic [COUNT_BITS-1:0]  fields_in_row_d;
	logic [HEADER_BITS-1:0] lines_skipped_d;
	logic [COUNT_BITS-1:0]  count_inc;
	logic [CHAR_BITS-1:0]   c;

	assign c = item.char_code;
	assign count_inc = (fields_in_row_q != COUNT_MAX) ?
		fields_in_row_q + COUNT_BITS'(1) : fields_in_row_q;

	always_comb begin
		escape_pending_d = escape_pending_q;
		open_quote_d     = open_quote_q;
		field_nonempty_d = field_nonempty_q;
		fields_in_row_d  = fields_in_row_q;
		lines_skipped_d  = lines_skipped_q;
		res              = '0;

		if (lines_skipped_q < cfg.header_lines) begin
			if (item.is_line_end && lines_skipped_q != SKIP_MAX)
				lines_skipped_d = lines_skipped_q + HEADER_BITS'(1);
		end else if (item.is_line_end) begin
			if (field_nonempty_q) begin
				res.field_end = 1'b1;
				res.row_field_count = (32'(count_inc) > 32'd255) ? 8'hFF : 8'(count_inc);
			end else begin
				res.row_field_count = (32'(fields_in_row_q) > 32'd255) ?
					8'hFF : 8'(fields_in_row_q);
			end
			res.row_end      = 1'b1;
			escape_pending_d = 1'b0;
			open_quote_d     = NUL_CODE;
			field_nonempty_d = 1'b0;
			fields_in_row_d  = '0;
		end else if (!escape_pending_q && c == BACKSLASH_CODE) begin
			escape_pending_d = 1'b1;
		end else if (escape_pending_q) begin
			escape_pending_d = 1'b0;
			res.out_char     = c;
			res.char_valid   = 1'b1;
			field_nonempty_d = 1'b1;
		end else if (open_quote_q == NUL_CODE && !field_nonempty_q &&
		             quote_match(cfg.quote_chars, c)) begin
			open_quote_d = c;
		end else if (open_quote_q != NUL_CODE && c == open_quote_q) begin
			open_quote_d = NUL_CODE;
		end else if (open_quote_q == NUL_CODE && delim_match(cfg.delimiter_chars, c)) begin
			res.field_end    = 1'b1;
			fields_in_row_d  = count_inc;
			field_nonempty_d = 1'b0;
		end else begin
			res.out_char     = c;
			res.char_valid   = 1'b1;
			field_nonempty_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_pending_q <= 1'b0;
			open_quote_q     <= NUL_CODE;
			field_nonempty_q <= 1'b0;
			fields_in_row_q  <= '0;
			lines_skipped_q  <= '0;
		end else if (adv) begin
			escape_pending_q <= escape_pending_d;
			open_quote_q     <= open_quote_d;
			field_nonempty_q <= field_nonempty_d;
			fields_in_row_q  <= fields_in_row_d;
			lines_skipped_q  <= lines_skipped_d;
		end
	end

endmodule

[src/csv_field_splitter_core.sv]
// top level of the csv field splitter: input register, tokenizer step, result register
// Splits a byte stream into CSV fields, one word (a character or a line end) per
// cycle while the output is not stalled, with one result word per input word. A
// word is registered on entry, runs through the tokenizer logic and its result lands
// in the output register when the held word advances; the single tokenizer state
// update per word sets the rate. The input register absorbs one word while the
// output is stalled. Configuration is written through cfg_we, cfg_index and
// cfg_data while no word is in flight; the user must keep to this, the block does not enforce it.
module csv_field_splitter_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [csvfs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [csvfs_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  csvfs_pkg::in_t                      in_word,
	output logic                                out_valid,
	input  logic                                out_stall,
	output csvfs_pkg::out_t                     out_word
);
	import csvfs_pkg::*;

	cfg_t cfg;
	in_t  in_word_s1;
	logic in_valid_s1;
	out_t res;
	out_t out_word_q;
	logic out_valid_q;
	logic adv;

	csvfs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	csvfs_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (in_word_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// the held word moves on whenever the output register is free or draining
	assign adv      = in_valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = in_valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			in_word_s1 <= in_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			out_word_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

[bench/tb_top.sv]
// self-checking testbench for the csv field splitter core
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import csvfs_pkg::*;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	in_t                      in_word = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	out_t                     out_word;

	csv_field_splitter_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// tokenizer shadow: configuration and state
	logic [DELIM_BITS-1:0]  delim_cfg = DELIM_RESET;
	logic [QUOTE_BITS-1:0]  quote_cfg = QUOTE_RESET;
	logic [HEADER_BITS-1:0] header_cfg = HEADER_RESET;
	logic                   esc_pend = 1'b0;
	logic [CHAR_BITS-1:0]   quote_open = '0;
	logic                   field_has_data = 1'b0;
	logic [COUNT_BITS-1:0]  row_fields = '0;
	logic [HEADER_BITS-1:0] skipped_lines = '0;

	out_t pending_results[$];

	int  words_sent = 0;
	int  results_checked = 0;
	int  rows_seen = 0;
	int  fields_seen = 0;
	int  settings_written = 0;
	int  error_count = 0;
	bit  idle_on = 1'b1;
	int  hold_req = 0;

	function automatic logic byte_in_slots(input logic [31:0] slots, input int n,
		input logic [CHAR_BITS-1:0] c);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < n; i++)
			if (slots[8*i +: 8] != 8'h00 && slots[8*i +: 8] == c)
				hit = 1'b1;
		return hit;
	endfunction

	function automatic out_t tokenize_word(input in_t w);
		out_t r;
		logic [CHAR_BITS-1:0] c;
		r = '0;
		c = w.char_code;
		if (skipped_lines < header_cfg) begin
			if (w.is_line_end && skipped_lines != SKIP_MAX)
				skipped_lines++;
		end else if (w.is_line_end) begin
			if (field_has_data) begin
				r.field_end = 1'b1;
				if (row_fields != COUNT_MAX)
					row_fields++;
			end
			r.row_end = 1'b1;
			r.row_field_count = row_fields;
			esc_pend = 1'b0;
			quote_open = '0;
			field_has_data = 1'b0;
			row_fields = '0;
		end else if (!esc_pend && c == BACKSLASH_CODE) begin
			esc_pend = 1'b1;
		end else if (esc_pend) begin
			esc_pend = 1'b0;
			r.out_char = c;
			r.char_valid = 1'b1;
			field_has_data = 1'b1;
		end else if (quote_open == '0 && !field_has_data &&
		             byte_in_slots({16'h0, quote_cfg}, QUOTE_SLOTS, c)) begin
			quote_open = c;
		end else if (quote_open != '0 && c == quote_open) begin
			quote_open = '0;
		end else if (quote_open == '0 && byte_in_slots(delim_cfg, DELIM_SLOTS, c)) begin
			r.field_end = 1'b1;
			if (row_fields != COUNT_MAX)
				row_fields++;
			field_has_data = 1'b0;
		end else begin
			r.out_char = c;
			r.char_valid = 1'b1;
			field_has_data = 1'b1;
		end
		return r;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [CHAR_BITS-1:0] pick_char();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return delim_cfg[8*$urandom_range(0, 3) +: 8];
			1: return quote_cfg[8*$urandom_range(0, 1) +: 8];
			2: return BACKSLASH_CODE;
			3: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			4, 5: return 8'($urandom_range(0, 255));
			default: return 8'($urandom_range(97, 122));
		endcase
	endfunction

	function automatic logic [31:0] random_slot_bytes(input int n);
		logic [31:0] v;
		int r;
		v = '0;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 3);
			if (r == 1)
				v[8*i +: 8] = 8'($urandom_range(0, 255));
			else if (r > 1)
				v[8*i +: 8] = 8'($urandom_range(33, 47));
		end
		return v;
	endfunction

	task automatic send_word(input logic [CHAR_BITS-1:0] c, input logic le);
		in_t w;
		out_t exp_res;
		int gap;
		w.char_code = c;
		w.is_line_end = le;
		@(negedge clk);
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (in_stall);
		exp_res = tokenize_word(w);
		pending_results.insert(pending_results.size(), exp_res);
		words_sent++;
		gap = idle_on ? gap_len() : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
		wait_for_results();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DELIM:  delim_cfg = val;
			REG_QUOTE:  quote_cfg = val[QUOTE_BITS-1:0];
			REG_HEADER: header_cfg = val[HEADER_BITS-1:0];
			default: ;
		endcase
		settings_written++;
	endtask

	// receiver stall pattern, with an occasional long hold-off
	always @(negedge clk) begin : stall_gen
		static int hold_left = 0;
		static int stall_left = 0;
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			stall_left = gap_len();
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : result_check
		out_t want;
		if (arst_n && out_valid && !out_stall) begin
			rows_seen += out_word.row_end;
			fields_seen += out_word.field_end;
			if (pending_results.size() == 0) begin
				if (error_count < 10)
					$display("unexpected result word: char %02h valid %b fend %b rend %b cnt %0d",
						out_word.out_char, out_word.char_valid, out_word.field_end,
						out_word.row_end, out_word.row_field_count);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_word.out_char !== want.out_char ||
				    out_word.char_valid !== want.char_valid ||
				    out_word.field_end !== want.field_end ||
				    out_word.row_end !== want.row_end ||
				    out_word.row_field_count !== want.row_field_count) begin
					if (error_count < 10)
						$display({"result %0d mismatch: expected char %02h valid %b fend %b ",
							"rend %b cnt %0d, got char %02h valid %b fend %b rend %b cnt %0d"},
							results_checked, want.out_char, want.char_valid,
							want.field_end, want.row_end, want.row_field_count,
							out_word.out_char, out_word.char_valid, out_word.field_end,
							out_word.row_end, out_word.row_field_count);
					error_count++;
				end
			end
			results_checked++;
		end
	end

	task automatic test_reset_defaults();
		// comma and double quote out of reset
		send_word("a", 1'b0);
		send_word(",", 1'b0);
		send_word("\"", 1'b0);
		send_word("b", 1'b0);
		send_word(",", 1'b0);
		send_word("\"", 1'b0);
		send_word("'", 1'b0);
		send_word(8'h00, 1'b1);
	endtask

	task automatic test_directed_cases();
		write_reg(REG_DELIM, {8'h00, 8'h09, 8'h3B, 8'h2C});
		write_reg(REG_QUOTE, {16'h0, 8'h27, 8'h22});
		send_word(8'h00, 1'b0);          // nul never matches an unused slot
		send_word(8'hFF, 1'b0);
		send_word(",", 1'b0);
		send_word(",", 1'b0);            // empty field
		send_word("\"", 1'b0);
		send_word(";", 1'b0);            // delimiter inside quotes
		send_word("'", 1'b0);            // other quote char inside quotes
		send_word("\"", 1'b0);
		send_word("a", 1'b0);
		send_word("\"", 1'b0);           // quote in a nonempty field is literal
		send_word(BACKSLASH_CODE, 1'b0);
		send_word(",", 1'b0);
		send_word(BACKSLASH_CODE, 1'b0);
		send_word(BACKSLASH_CODE, 1'b0);
		send_word(8'h09, 1'b0);
		send_word(8'hFF, 1'b1);          // char code ignored on line end
		send_word(8'h00, 1'b1);          // empty row
		send_word("'", 1'b0);
		send_word("'", 1'b0);
		send_word(8'h00, 1'b1);          // empty quoted field, no field end
		send_word("q", 1'b0);
		send_word(BACKSLASH_CODE, 1'b0);
		send_word(8'h00, 1'b1);          // line end with escape pending
		send_word("\"", 1'b0);
		send_word("r", 1'b0);
		send_word(8'h00, 1'b1);          // line end inside quotes
	endtask

	task automatic test_header_skip();
		write_reg(REG_HEADER, 32'd2);
		send_word("h", 1'b0);
		send_word(8'h00, 1'b1);
		send_word(8'h00, 1'b1);
		send_word("a", 1'b0);
		send_word(",", 1'b0);
		send_word("b", 1'b0);
		send_word(8'h00, 1'b1);
		// raising the count skips two more lines
		write_reg(REG_HEADER, 32'd4);
		send_word("x", 1'b0);
		send_word(",", 1'b0);
		send_word(8'h00, 1'b1);
		send_word(8'h00, 1'b1);
		send_word("c", 1'b0);
		send_word(8'h00, 1'b1);
		write_reg(REG_HEADER, 32'd255);
		send_word("k", 1'b0);
		send_word(8'h00, 1'b1);
		send_word("m", 1'b0);
		write_reg(REG_HEADER, 32'd0);
		send_word("n", 1'b0);
		send_word(8'h00, 1'b1);
	endtask

	task automatic test_count_saturation();
		write_reg(REG_DELIM, 32'h0000_002C);
		send_word("x", 1'b0);
		repeat (300) send_word(",", 1'b0);
		send_word("z", 1'b0);
		send_word(8'h00, 1'b1);
	endtask

	task automatic test_backpressure();
		// receiver holds off while words keep coming back to back
		idle_on = 1'b0;
		hold_req = 200;
		repeat (40) send_word(pick_char(), 1'b0);
		send_word(8'h00, 1'b1);
		wait_for_results();
		idle_on = 1'b1;
	endtask

	task automatic random_row();
		int nf;
		int len;
		logic quoted;
		logic [CHAR_BITS-1:0] q;
		nf = $urandom_range(0, 5);
		for (int f = 0; f < nf; f++) begin
			if (f > 0)
				send_word(delim_cfg[8*$urandom_range(0, 3) +: 8], 1'b0);
			quoted = ($urandom_range(0, 2) == 0);
			q = quote_cfg[8*$urandom_range(0, 1) +: 8];
			if (quoted)
				send_word(q, 1'b0);
			len = $urandom_range(0, 4);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(0, 6) == 0)
					send_word(BACKSLASH_CODE, 1'b0);
				send_word(pick_char(), 1'b0);
			end
			// sometimes leave the quote open
			if (quoted && $urandom_range(0, 9) != 0)
				send_word(q, 1'b0);
		end
		send_word(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic test_random_rows(input logic [31:0] delims, input logic [31:0] quotes,
		input int n_words, input bit with_idle);
		int start;
		write_reg(REG_DELIM, delims);
		write_reg(REG_QUOTE, quotes);
		idle_on = with_idle;
		start = words_sent;
		while (words_sent - start < n_words) begin
			if ($urandom_range(0, 9) < 8)
				random_row();
			else
				repeat ($urandom_range(1, 6))
					send_word(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
		end
		wait_for_results();
		idle_on = 1'b1;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_directed_cases();
		test_header_skip();
		test_count_saturation();
		test_backpressure();
		test_random_rows(32'h7C09_3B2C, 32'h0000_2722, 200, 1'b1);
		test_random_rows(32'h0000_0000, 32'h0000_0000, 100, 1'b1);
		test_random_rows(32'hFFFF_FFFF, 32'h0000_FFFF, 100, 1'b1);
		test_random_rows(random_slot_bytes(4), random_slot_bytes(2), 175, 1'b0);
		test_random_rows(random_slot_bytes(4), random_slot_bytes(2), 175, 1'b1);
		wait_for_results();
		repeat (10) @(posedge clk);
		$display("%0d words sent, %0d result words checked, %0d errors",
			words_sent, results_checked, error_count);
		$display("%0d rows and %0d fields seen over %0d register writes",
			rows_seen, fields_seen, settings_written);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("timeout with %0d result words outstanding", pending_results.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
